// ===== hw/rtl/lom_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types and constants of the limit order matcher.
// ----------------------------------------------------------------------------
package lom_pkg;

    localparam int ORDERS     = 64;
    localparam int USERS      = 256;
    localparam int PRICE_BITS = 16;
    localparam int SLOT_W     = $clog2(ORDERS);
    localparam int UCNT_W     = $clog2(USERS + 1);
    localparam int QTY_W      = 31;
    localparam int STAMP_W    = 32;

    localparam logic [1:0] FUNC_BUY    = 2'd0;
    localparam logic [1:0] FUNC_SELL   = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;
    localparam logic [1:0] FUNC_USER   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_USER  = 2'd1;
    localparam logic [1:0] ST_NO_ORDER = 2'd2;
    localparam logic [1:0] ST_NO_ROOM  = 2'd3;

    // One resting order as held in the slot memory
    typedef struct packed {
        logic                  is_buy;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_W-1:0]      amount;
        logic [7:0]            owner;
        logic [STAMP_W-1:0]    stamp;
    } slot_t;

    // Memory port requests from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        slot_t             wr_data;
    } mem_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_FREE,
        S_OUT
    } state_t;

endpackage

// ===== hw/rtl/lom_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_slot_ram
// Order slot memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lom_slot_ram (
    input  logic             aclk,
    input  lom_pkg::mem_req_t req,
    output lom_pkg::slot_t   rd_data
);
    import lom_pkg::*;

    slot_t mem [ORDERS];

    // Write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== hw/rtl/limit_order_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_matcher
// Price-time priority limit order book with a 64-slot resting order store.
// ----------------------------------------------------------------------------
// Usage: commands enter on the s_ stream, one beat each; s_tuser carries the
// function (place buy, place sell, cancel, create user). Results leave on the
// m_ stream; a place gives one beat per fill, and its final beat carries tlast
// with status, rested quantity and slot. m_tuser marks a trade beat.
// Slot fields live in a synchronous RAM with one registered read; live bits
// sit in flip-flops. Each fill searches all 64 slots through the read port,
// then writes the slot back. A place ends with one more scan when a remainder
// is left after fewer than 64 fills, then a closing state. A trade beat is
// held back until the next fill or the closing state, so the final fields
// ride on the last fill. Cancel, create user, an unknown user and a zero
// quantity skip the scan. s_tready is high only when idle with a free output
// register: a new command is taken only after the last one is done. Reset
// clears the live bits, user count and arrival counter at once; no clearing
// pass is needed. A stalled receiver holds the result register and the sequencer
// waits on it before each fill, closing and output step; nothing is lost.
// ----------------------------------------------------------------------------
module limit_order_matcher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tuser: func[1:0]
    input  logic [1:0]   s_tuser,
    // tdata: user_id[7:0], limit_price[23:8], quantity[54:24],
    //        order_ref[60:55], zero pad
    input  logic [63:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tuser: trade_valid[0]
    output logic         m_tuser,
    // tdata: buyer_id[7:0], seller_id[15:8], trade_price[31:16],
    //        trade_quantity[62:32], status[64:63], rested_quantity[95:65],
    //        new_id[103:96]
    output logic [103:0] m_tdata,
    output logic         m_tlast
);
    import lom_pkg::*;

    state_t state_reg, state_next;

    logic [ORDERS-1:0]     live_reg, live_next;
    logic [UCNT_W-1:0]     ucnt_reg, ucnt_next;
    logic [STAMP_W-1:0]    arr_reg, arr_next;

    // Command fields on the input stream
    logic [1:0]            in_func;
    logic [7:0]            in_user;
    logic [PRICE_BITS-1:0] in_limit;
    logic [QTY_W-1:0]      in_qty;
    logic [SLOT_W-1:0]     in_ref;

    // Current command
    logic [1:0]            func_reg;
    logic [7:0]            user_reg;
    logic [PRICE_BITS-1:0] limit_reg;
    logic [QTY_W-1:0]      rem_reg, rem_next;
    logic [6:0]            nfill_reg, nfill_next;

    // Scan control
    logic [SLOT_W:0]       cnt_reg, cnt_next;
    logic                  rvalid_reg;
    logic [SLOT_W-1:0]     raddr_reg;
    logic                  bfound_reg, bfound_next;
    logic [SLOT_W-1:0]     bidx_reg, bidx_next;
    slot_t                 best_reg, best_next;

    // Trade beat waiting for the next fill or the closing state
    logic [104:0]          hold_reg, hold_next;

    // Output register, trade_valid in bit 0
    logic                  ov_reg, ov_next;
    logic [104:0]          od_reg, od_next;
    logic                  ol_reg, ol_next;

    mem_req_t              req;
    slot_t                 rd;

    lom_slot_ram u_ram (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd)
    );

    logic buying;
    logic cand_ok, better;
    logic [STAMP_W-1:0] age_c, age_b;
    logic [QTY_W-1:0] fill;
    logic [SLOT_W-1:0] free_idx;
    logic free_any;
    logic out_free;

    assign in_func  = s_tuser;
    assign in_user  = s_tdata[7:0];
    assign in_limit = s_tdata[23:8];
    assign in_qty   = s_tdata[54:24];
    assign in_ref   = s_tdata[60:55];

    assign buying   = (func_reg == FUNC_BUY);
    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;

    // Candidate qualification and comparison against current best
    always_comb begin
        age_c   = arr_reg - rd.stamp;
        age_b   = arr_reg - best_reg.stamp;
        cand_ok = rvalid_reg && live_reg[raddr_reg] && (rd.is_buy != buying)
                  && (buying ? (rd.price <= limit_reg) : (rd.price >= limit_reg));
        if (!bfound_reg) begin
            better = 1'b1;
        end else if (rd.price == best_reg.price) begin
            better = age_c > age_b;
        end else begin
            better = buying ? (rd.price < best_reg.price) : (rd.price > best_reg.price);
        end
    end

    assign fill = (rem_reg < best_reg.amount) ? rem_reg : best_reg.amount;

    // Lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ORDERS - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    function automatic logic [104:0] pack_out(
        input logic tv, input logic [7:0] b, input logic [7:0] s,
        input logic [15:0] p, input logic [30:0] q, input logic [1:0] st,
        input logic [30:0] r, input logic [7:0] nid);
        pack_out = {nid, r, st, q, p, s, b, tv};
    endfunction

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (in_func == FUNC_USER || in_func == FUNC_CANCEL
                        || {1'b0, in_user} >= ucnt_reg || in_qty == '0) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (cnt_reg == (SLOT_W+1)'(ORDERS) && !rvalid_reg) begin
                    state_next = bfound_reg ? S_FILL : S_FREE;
                end
            end
            S_FILL: begin
                if (out_free) begin
                    if (rem_reg == fill || nfill_reg == 7'(ORDERS - 1)) begin
                        state_next = S_FREE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_FREE: begin
                if (out_free) state_next = S_IDLE;
            end
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        live_next   = live_reg;
        ucnt_next   = ucnt_reg;
        arr_next    = arr_reg;
        rem_next    = rem_reg;
        nfill_next  = nfill_reg;
        cnt_next    = cnt_reg;
        bfound_next = bfound_reg;
        bidx_next   = bidx_reg;
        best_next   = best_reg;
        hold_next   = hold_reg;
        ov_next     = ov_reg && !m_tready;
        od_next     = od_reg;
        ol_next     = ol_reg;
        req         = '0;
        case (state_reg)
            S_IDLE: begin
                rem_next    = in_qty;
                nfill_next  = '0;
                cnt_next    = '0;
                bfound_next = 1'b0;
                // fetch the cancel target early
                req.rd_en   = 1'b1;
                req.rd_addr = in_ref;
            end
            S_SCAN: begin
                if (cnt_reg != (SLOT_W+1)'(ORDERS)) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = cnt_reg[SLOT_W-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (cand_ok && better) begin
                    bfound_next = 1'b1;
                    bidx_next   = raddr_reg;
                    best_next   = rd;
                end
            end
            S_FILL: begin
                if (out_free) begin
                    // release the previous trade, hold this one
                    if (nfill_reg != '0) begin
                        ov_next = 1'b1;
                        ol_next = 1'b0;
                        od_next = hold_reg;
                    end
                    hold_next = pack_out(1'b1, buying ? user_reg : best_reg.owner,
                                         buying ? best_reg.owner : user_reg,
                                         16'(best_reg.price), fill, ST_OK, '0, '0);
                    req.wr_en        = 1'b1;
                    req.wr_addr      = bidx_reg;
                    req.wr_data      = best_reg;
                    req.wr_data.amount = best_reg.amount - fill;
                    if (best_reg.amount == fill) live_next[bidx_reg] = 1'b0;
                    rem_next    = rem_reg - fill;
                    nfill_next  = nfill_reg + 1'b1;
                    cnt_next    = '0;
                    bfound_next = 1'b0;
                end
            end
            S_FREE: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    ol_next = 1'b1;
                    od_next = (nfill_reg == '0) ? '0 : hold_reg;
                    od_next[65:64]  = ST_OK;
                    od_next[96:66]  = '0;
                    od_next[104:97] = '0;
                    if (rem_reg != '0) begin
                        if (!free_any) begin
                            od_next[65:64] = ST_NO_ROOM;
                        end else begin
                            live_next[free_idx] = 1'b1;
                            req.wr_en   = 1'b1;
                            req.wr_addr = free_idx;
                            req.wr_data = '{is_buy: buying, price: limit_reg,
                                            amount: rem_reg, owner: user_reg,
                                            stamp: arr_reg};
                            arr_next = arr_reg + 1'b1;
                            od_next[96:66]  = rem_reg;
                            od_next[104:97] = 8'(free_idx);
                        end
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    ol_next = 1'b1;
                    od_next = '0;
                    if (func_reg == FUNC_USER) begin
                        if (ucnt_reg >= UCNT_W'(USERS)) begin
                            od_next[65:64] = ST_NO_ROOM;
                        end else begin
                            od_next[104:97] = 8'(ucnt_reg);
                            ucnt_next = ucnt_reg + 1'b1;
                        end
                    end else if ({1'b0, user_reg} >= ucnt_reg) begin
                        od_next[65:64] = ST_NO_USER;
                    end else if (func_reg == FUNC_CANCEL) begin
                        if (!live_reg[raddr_reg] || rd.owner != user_reg) begin
                            od_next[65:64] = ST_NO_ORDER;
                        end else begin
                            live_next[raddr_reg] = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            live_reg   <= '0;
            ucnt_reg   <= '0;
            arr_reg    <= '0;
            ov_reg     <= 1'b0;
            rvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            live_reg   <= live_next;
            ucnt_reg   <= ucnt_next;
            arr_reg    <= arr_next;
            ov_reg     <= ov_next;
            rvalid_reg <= req.rd_en && (state_reg == S_SCAN);
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg  <= in_func;
            user_reg  <= in_user;
            limit_reg <= in_limit;
        end
        if (req.rd_en) raddr_reg <= req.rd_addr;
        rem_reg    <= rem_next;
        nfill_reg  <= nfill_next;
        cnt_reg    <= cnt_next;
        bfound_reg <= bfound_next;
        bidx_reg   <= bidx_next;
        best_reg   <= best_next;
        hold_reg   <= hold_next;
        od_reg     <= od_next;
        ol_reg     <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = od_reg[0];
    assign m_tdata  = od_reg[104:1];
    assign m_tlast  = ol_reg;

endmodule

// ===== tb/sv/limit_order_matcher_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_matcher_checker
// Watches both streams of the order matcher, keeps its own copy of the
// order book, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module limit_order_matcher_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [1:0]   s_tuser,
    input  logic [63:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         m_tuser,
    input  logic [103:0] m_tdata,
    input  logic         m_tlast,
    output int           errors,
    output int           pending
);
    import lom_pkg::*;

    typedef struct packed {
        logic        trade_valid;
        logic [7:0]  buyer_id;
        logic [7:0]  seller_id;
        logic [15:0] trade_price;
        logic [30:0] trade_quantity;
        logic [1:0]  status;
        logic [30:0] rested_quantity;
        logic [7:0]  new_id;
        logic        last;
    } fill_beat_t;

    // Book copy
    logic        book_live   [ORDERS];
    logic        book_is_buy [ORDERS];
    logic [15:0] book_price  [ORDERS];
    logic [30:0] book_amount [ORDERS];
    logic [7:0]  book_owner  [ORDERS];
    logic [31:0] book_stamp  [ORDERS];
    logic [31:0] arrivals;
    int          users_known;

    fill_beat_t  expected_fills[$];

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    function automatic fill_beat_t final_beat(input logic [1:0] st,
                                              input logic [30:0] rested,
                                              input logic [7:0] nid);
        fill_beat_t b;
        b = '0;
        b.status = st;
        b.rested_quantity = rested;
        b.new_id = nid;
        b.last = 1'b1;
        return b;
    endfunction

    // Best counter order for an incoming order, -1 if none crosses
    function automatic int best_counter(input logic buying, input logic [15:0] lim);
        int best;
        best = -1;
        for (int i = 0; i < ORDERS; i++) begin
            if (!book_live[i] || book_is_buy[i] == buying) continue;
            if (buying ? (book_price[i] > lim) : (book_price[i] < lim)) continue;
            if (best < 0) begin
                best = i;
            end else if (buying ? (book_price[i] < book_price[best])
                                : (book_price[i] > book_price[best])) begin
                best = i;
            end else if (book_price[i] == book_price[best]) begin
                if (32'(arrivals - book_stamp[i]) > 32'(arrivals - book_stamp[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    // Apply one command to the book and queue the beats it should produce
    function automatic void book_apply(input logic [1:0] cmd_func,
                                       input logic [63:0] cmd);
        logic [1:0]  func;
        logic [7:0]  user;
        logic [15:0] lim;
        logic [30:0] remaining;
        logic [30:0] fill;
        logic [5:0]  ref_slot;
        logic        buying;
        int          fills;
        int          s;
        int          free_slot;
        fill_beat_t  b;
        func      = cmd_func;
        user      = cmd[7:0];
        lim       = cmd[23:8];
        remaining = cmd[54:24];
        ref_slot  = cmd[60:55];
        if (func == FUNC_USER) begin
            if (users_known >= USERS) begin
                expected_fills.insert(expected_fills.size(),
                                      final_beat(ST_NO_ROOM, '0, '0));
            end else begin
                expected_fills.insert(expected_fills.size(),
                                      final_beat(ST_OK, '0, 8'(users_known)));
                users_known++;
            end
            return;
        end
        if (int'(user) >= users_known) begin
            expected_fills.insert(expected_fills.size(), final_beat(ST_NO_USER, '0, '0));
            return;
        end
        if (func == FUNC_CANCEL) begin
            if (!book_live[ref_slot] || book_owner[ref_slot] != user) begin
                expected_fills.insert(expected_fills.size(),
                                      final_beat(ST_NO_ORDER, '0, '0));
            end else begin
                book_live[ref_slot] = 1'b0;
                expected_fills.insert(expected_fills.size(), final_beat(ST_OK, '0, '0));
            end
            return;
        end
        buying = (func == FUNC_BUY);
        fills = 0;
        // Match against the book in price-time order
        while (remaining != 0 && fills < ORDERS) begin
            s = best_counter(buying, lim);
            if (s < 0) break;
            fill = (remaining < book_amount[s]) ? remaining : book_amount[s];
            b = '0;
            b.trade_valid = 1'b1;
            b.buyer_id = buying ? user : book_owner[s];
            b.seller_id = buying ? book_owner[s] : user;
            b.trade_price = book_price[s];
            b.trade_quantity = fill;
            expected_fills.insert(expected_fills.size(), b);
            fills++;
            book_amount[s] -= fill;
            remaining -= fill;
            if (book_amount[s] == 0) book_live[s] = 1'b0;
        end
        b = final_beat(ST_OK, '0, '0);
        // Rest any remainder in the lowest free slot
        if (remaining != 0) begin
            free_slot = -1;
            for (int i = ORDERS - 1; i >= 0; i--)
                if (!book_live[i]) free_slot = i;
            if (free_slot < 0) begin
                b.status = ST_NO_ROOM;
            end else begin
                book_live[free_slot] = 1'b1;
                book_is_buy[free_slot] = buying;
                book_price[free_slot] = lim;
                book_amount[free_slot] = remaining;
                book_owner[free_slot] = user;
                book_stamp[free_slot] = arrivals;
                arrivals++;
                b.rested_quantity = remaining;
                b.new_id = 8'(free_slot);
            end
        end
        if (fills == 0) begin
            expected_fills.insert(expected_fills.size(), b);
        end else begin
            expected_fills[$].status = b.status;
            expected_fills[$].rested_quantity = b.rested_quantity;
            expected_fills[$].new_id = b.new_id;
            expected_fills[$].last = 1'b1;
        end
    endfunction

    // Predict on accepted commands, compare on accepted results
    always @(posedge aclk) begin
        fill_beat_t want;
        fill_beat_t got;
        if (!aresetn) begin
            for (int i = 0; i < ORDERS; i++) begin
                book_live[i] = 1'b0;
                book_is_buy[i] = 1'b0;
                book_price[i] = '0;
                book_amount[i] = '0;
                book_owner[i] = '0;
                book_stamp[i] = '0;
            end
            arrivals = '0;
            users_known = 0;
            expected_fills.delete();
        end else begin
            if (s_tvalid && s_tready)
                book_apply(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[31:16],
                       m_tdata[62:32], m_tdata[64:63], m_tdata[95:65],
                       m_tdata[103:96], m_tlast};
                if (expected_fills.size() == 0) begin
                    report("unexpected beat", 32'(got.trade_quantity), 32'd0);
                end else begin
                    want = expected_fills[0];
                    expected_fills.delete(0);
                    if (got.trade_valid != want.trade_valid)
                        report("trade_valid", 32'(got.trade_valid), 32'(want.trade_valid));
                    if (got.buyer_id != want.buyer_id)
                        report("buyer_id", 32'(got.buyer_id), 32'(want.buyer_id));
                    if (got.seller_id != want.seller_id)
                        report("seller_id", 32'(got.seller_id), 32'(want.seller_id));
                    if (got.trade_price != want.trade_price)
                        report("trade_price", 32'(got.trade_price), 32'(want.trade_price));
                    if (got.trade_quantity != want.trade_quantity)
                        report("trade_quantity", 32'(got.trade_quantity),
                               32'(want.trade_quantity));
                    if (got.status != want.status)
                        report("status", 32'(got.status), 32'(want.status));
                    if (got.rested_quantity != want.rested_quantity)
                        report("rested_quantity", 32'(got.rested_quantity),
                               32'(want.rested_quantity));
                    if (got.new_id != want.new_id)
                        report("new_id", 32'(got.new_id), 32'(want.new_id));
                    if (got.last != want.last)
                        report("tlast", 32'(got.last), 32'(want.last));
                end
            end
        end
        pending = expected_fills.size();
    end

endmodule

// ===== tb/sv/limit_order_matcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_matcher_test
// Drives directed and random commands into the order matcher under varying
// back-pressure; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module limit_order_matcher_test;
    import lom_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         m_tuser;
    logic [103:0] m_tdata;
    logic         m_tlast;
    int           errors;
    int           pending;
    int           send_idle_pct;
    int           recv_stall_pct;

    limit_order_matcher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    limit_order_matcher_checker book_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver stalls at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hold one command beat until it is taken
    task automatic send(input logic [1:0] func, input logic [7:0] user,
                        input logic [15:0] price, input logic [30:0] qty,
                        input logic [5:0] slot);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = func;
        s_tdata = {3'b0, slot, qty, price, user};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic random_command();
        logic [1:0]  func;
        logic [7:0]  user;
        logic [15:0] price;
        logic [30:0] qty;
        int          pick;
        pick = $urandom_range(99);
        func = (pick < 43) ? FUNC_BUY : (pick < 86) ? FUNC_SELL :
               (pick < 97) ? FUNC_CANCEL : FUNC_USER;
        user = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
        price = ($urandom_range(4) == 0) ? 16'($urandom) : 16'(1000 + $urandom_range(20));
        qty = ($urandom_range(6) == 0) ? 31'($urandom) : 31'($urandom_range(100));
        send(func, user, price, qty, 6'($urandom));
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        aresetn = 1'b0;
        send_idle_pct = 16;
        recv_stall_pct = 56;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: unknown user, bad cancels, zero quantity, extremes
        send(FUNC_BUY, 8'd0, 16'd100, 31'd5, 6'd0);
        repeat (4) send(FUNC_USER, 8'd0, 16'd0, 31'd0, 6'd0);
        send(FUNC_CANCEL, 8'd0, 16'd0, 31'd0, 6'd0);
        send(FUNC_BUY, 8'd0, 16'd100, 31'd0, 6'd0);
        send(FUNC_SELL, 8'd1, 16'hFFFF, 31'h7FFF_FFFF, 6'd0);
        send(FUNC_BUY, 8'd2, 16'd0, 31'd5, 6'd0);
        send(FUNC_CANCEL, 8'd3, 16'd0, 31'd0, 6'd0);
        send(FUNC_CANCEL, 8'd1, 16'd0, 31'd0, 6'd0);
        send(FUNC_SELL, 8'd3, 16'd200, 31'd10, 6'd0);
        send(FUNC_SELL, 8'd1, 16'd200, 31'd10, 6'd0);
        send(FUNC_SELL, 8'd3, 16'd150, 31'd4, 6'd0);
        send(FUNC_BUY, 8'd2, 16'd200, 31'd30, 6'd0);
        // self match against own resting buys
        send(FUNC_SELL, 8'd2, 16'd0, 31'd8, 6'd0);
        send(FUNC_SELL, 8'd4, 16'd10, 31'd1, 6'd0);
        send(FUNC_CANCEL, 8'd200, 16'd0, 31'd0, 6'd63);
        send(FUNC_CANCEL, 8'd2, 16'd0, 31'd0, 6'd63);

        // Fill the book with buys until it runs out of room
        for (int i = 0; i < 66; i++)
            send(FUNC_BUY, 8'($urandom_range(3)), 16'($urandom_range(1, 50)),
                 31'($urandom_range(1, 20)), 6'd0);
        drain();
        // Sweep the whole book, then cancel the remainder that rests in slot 0
        send(FUNC_SELL, 8'd1, 16'd0, 31'h7FFF_FFFF, 6'd0);
        send(FUNC_CANCEL, 8'd1, 16'd0, 31'd0, 6'd0);

        // Use up the user space, one create beyond it
        for (int i = 4; i <= USERS; i++)
            send(FUNC_USER, 8'd0, 16'd0, 31'd0, 6'd0);

        // Random phases with swapped idling, then none
        for (int i = 0; i < 40; i++) random_command();
        drain();
        send_idle_pct = 56;
        recv_stall_pct = 16;
        for (int i = 0; i < 40; i++) random_command();
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 40; i++) random_command();
        drain();
        repeat (200) @(negedge aclk);

        if (errors == 0 && pending == 0) begin
            $display("limit_order_matcher_test OK");
        end else begin
            $display("limit_order_matcher_test NOT OK");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("limit_order_matcher_test NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lom_pkg.sv
hw/rtl/lom_slot_ram.sv
hw/rtl/limit_order_matcher.sv
tb/sv/limit_order_matcher_checker.sv
tb/sv/limit_order_matcher_test.sv
